[src/thvn_pkg.sv]
// shared types, constants and job decode for the terrain height value noise block
package thvn_pkg;

  // noise space coordinates carry 16 fraction bits
  localparam int unsigned CW = 40;
  localparam int unsigned NW = 48;

  localparam logic [31:0] HASH_KX  = 32'd374761393;
  localparam logic [31:0] HASH_KZ  = 32'd668265263;
  localparam logic [31:0] HASH_MIX = 32'd1274126177;

  localparam logic signed [14:0]   CONT_SCALE = 15'sd9830;
  localparam logic signed [CW-1:0] CONT_OFS   = 40'sd6553600;
  localparam logic signed [CW-1:0] RIDGE_OFS  = 40'sd3276800;

  localparam logic signed [25:0] Q24_ONE_S = 26'sd16777216;
  localparam logic signed [25:0] EDGE0     = 26'sd838861;
  localparam logic signed [25:0] K_LAND    = 26'sd14260634;
  localparam logic signed [25:0] K_HILL    = 26'sd5872026;
  localparam logic [25:0]        K_RIDGE   = 26'd43620762;

  localparam int unsigned JOBS   = 15;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // fractal sums are divided by 2^oct - 1 through a reciprocal and one correction
  localparam logic [5:0]  DIV_CONT    = 6'd15;
  localparam logic [5:0]  DIV_BASE    = 6'd63;
  localparam logic [5:0]  DIV_RIDGE   = 6'd31;
  localparam logic [32:0] RECIP_CONT  = 33'((64'd1 << 36) / 64'd15);
  localparam logic [32:0] RECIP_BASE  = 33'((64'd1 << 36) / 64'd63);
  localparam logic [32:0] RECIP_RIDGE = 33'((64'd1 << 36) / 64'd31);

  localparam logic [1:0] FRAC_CONT  = 2'd0;
  localparam logic [1:0] FRAC_BASE  = 2'd1;
  localparam logic [1:0] FRAC_RIDGE = 2'd2;

  localparam logic [2:0] REG_SEED        = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd1;
  localparam logic [2:0] REG_FREQUENCY   = 3'd2;
  localparam logic [2:0] REG_SHORE_LEVEL = 3'd3;
  localparam logic [2:0] REG_WATER_DEPTH = 3'd4;

  typedef struct packed {
    logic signed [31:0] seed;
    logic [19:0]        amplitude;
    logic [23:0]        frequency;
    logic signed [23:0] shore_level;
    logic [15:0]        water_depth;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cz;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] rz;
  } coord_t;

  typedef struct packed {
    logic [1:0] frac;
    logic [2:0] oct;
    logic [2:0] shift;
    logic       first;
    logic       last_frac;
    logic       last_item;
  } tag_t;

  // job order: continent octaves 0..3, hills 0..5, ridges 0..4
  function automatic tag_t job_decode(input logic [3:0] job);
    tag_t t;
    logic [2:0] o;
    t = '0;
    if (job < 4'd4) begin
      o = job[2:0];
      t.frac = FRAC_CONT;
      t.shift = 3'd3 - o;
      t.last_frac = (o == 3'd3);
    end else if (job < 4'd10) begin
      o = 3'(job - 4'd4);
      t.frac = FRAC_BASE;
      t.shift = 3'd5 - o;
      t.last_frac = (o == 3'd5);
    end else begin
      o = 3'(job - 4'd10);
      t.frac = FRAC_RIDGE;
      t.shift = 3'd4 - o;
      t.last_frac = (o == 3'd4);
    end
    t.oct = o;
    t.first = (o == 3'd0);
    t.last_item = (job == 4'(JOBS - 1));
    return t;
  endfunction

endpackage

[src/thvn_pos_if.sv]
// position channel: valid/ready with world x and z
interface thvn_pos_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_z;
  modport source (output valid, world_x, world_z, input ready);
  modport sink (input valid, world_x, world_z, output ready);
endinterface

[src/thvn_hgt_if.sv]
// height channel: valid/ready with terrain height
interface thvn_hgt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height;
  modport source (output valid, height, input ready);
  modport sink (input valid, height, output ready);
endinterface

[src/thvn_front.sv]
// front end: scales a position into noise space and derives the three coordinate sets
module thvn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [23:0]        frequency,
  thvn_pos_if.sink           position,
  input  logic               full,
  output logic               push_valid,
  output thvn_pkg::coord_t   push_word
);

  logic v1, v2, v3;
  logic en;
  logic signed [56:0] px, pz;
  logic signed [thvn_pkg::CW-1:0] fx2, fz2;
  logic signed [54:0] sx, sz;
  thvn_pkg::coord_t c3;

  assign en = !v3 || !full;
  assign position.ready = en;
  assign push_valid = v3;
  assign push_word = c3;

  assign sx = fx2 * thvn_pkg::CONT_SCALE;
  assign sz = fz2 * thvn_pkg::CONT_SCALE;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= position.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px <= position.world_x * $signed({1'b0, frequency});
      pz <= position.world_z * $signed({1'b0, frequency});
      fx2 <= thvn_pkg::CW'(px >>> 16);
      fz2 <= thvn_pkg::CW'(pz >>> 16);
      c3.fx <= fx2;
      c3.fz <= fz2;
      c3.cx <= thvn_pkg::CW'(sx >>> 16) + thvn_pkg::CONT_OFS;
      c3.cz <= thvn_pkg::CW'(sz >>> 16) + thvn_pkg::CONT_OFS;
      c3.rx <= (fx2 >>> 1) + thvn_pkg::RIDGE_OFS;
      c3.rz <= (fz2 >>> 1) + thvn_pkg::RIDGE_OFS;
    end
  end

endmodule

[src/thvn_queue.sv]
// small fifo of coordinate words between front and back
module thvn_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  thvn_pkg::coord_t push_word,
  output logic             full,
  output logic             head_valid,
  output thvn_pkg::coord_t head,
  input  logic             pop
);

  thvn_pkg::coord_t mem [thvn_pkg::QDEPTH];
  logic [thvn_pkg::QAW-1:0] wr, rd;
  logic [thvn_pkg::QCW-1:0] count;
  logic push;

  assign full = (count == thvn_pkg::QCW'(thvn_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd];
  assign push = push_valid && !full;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= wr + 1'b1;
      end
      if (pop) begin
        rd <= rd + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= thvn_pkg::QCW'(thvn_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

[src/thvn_noise.sv]
// pipelined lattice value noise: seven stages, one sample per enabled cycle
module thvn_noise (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  thvn_pkg::tag_t           in_tag,
  input  logic [thvn_pkg::NW-1:0]  x,
  input  logic [thvn_pkg::NW-1:0]  z,
  input  logic [31:0]              seed,
  output logic                     out_valid,
  output thvn_pkg::tag_t           out_tag,
  output logic [23:0]              value
);

  localparam logic [33:0] BLEND3 = 34'd196608;

  logic [6:0] v;
  thvn_pkg::tag_t tg [7];

  // stage 1
  logic [31:0] xi, zi;
  logic [31:0] pxi, pxn, pzi, pzn;
  logic [15:0] fx1, fz1, sqx, sqz;
  // stage 2
  logic [31:0] h [4];
  logic [31:0] a2 [4];
  logic [16:0] u2, v2w;
  logic [33:0] wu, wv;
  // stage 3
  logic [31:0] m3 [4];
  logic [16:0] u3, v3w;
  // stage 4
  logic [23:0] n [4];
  logic [23:0] n0_4, n2_4;
  logic signed [24:0] d_top, d_bot;
  logic signed [42:0] pt4, pb4;
  logic [16:0] v4w;
  // stage 5
  logic signed [24:0] top5, bot5;
  logic [16:0] v5w;
  // stage 6
  logic signed [42:0] dv6;
  logic signed [24:0] top6;
  logic signed [24:0] vmix;

  assign xi = x[47:16];
  assign zi = z[47:16];

  assign h[0] = pxi + pzi + seed;
  assign h[1] = pxn + pzi + seed;
  assign h[2] = pxi + pzn + seed;
  assign h[3] = pxn + pzn + seed;

  assign wu = 34'(sqx) * (BLEND3 - 34'({fx1, 1'b0}));
  assign wv = 34'(sqz) * (BLEND3 - 34'({fz1, 1'b0}));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      n[k] = m3[k][23:0] ^ m3[k][31:16];
    end
  end

  assign d_top = $signed({1'b0, n[1]}) - $signed({1'b0, n[0]});
  assign d_bot = $signed({1'b0, n[3]}) - $signed({1'b0, n[2]});
  assign vmix = bot5 - top5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg[0] <= in_tag;
      for (int k = 1; k < 7; k++) begin
        tg[k] <= tg[k-1];
      end
      // lattice products and squared fractions
      pxi <= xi * thvn_pkg::HASH_KX;
      pxn <= (xi + 32'd1) * thvn_pkg::HASH_KX;
      pzi <= zi * thvn_pkg::HASH_KZ;
      pzn <= (zi + 32'd1) * thvn_pkg::HASH_KZ;
      fx1 <= x[15:0];
      fz1 <= z[15:0];
      sqx <= 16'((32'(x[15:0]) * 32'(x[15:0])) >> 16);
      sqz <= 16'((32'(z[15:0]) * 32'(z[15:0])) >> 16);
      // hash fold and blend weights
      for (int k = 0; k < 4; k++) begin
        a2[k] <= h[k] ^ (h[k] >> 13);
      end
      u2 <= wu[32:16];
      v2w <= wv[32:16];
      // hash multiply
      for (int k = 0; k < 4; k++) begin
        m3[k] <= a2[k] * thvn_pkg::HASH_MIX;
      end
      u3 <= u2;
      v3w <= v2w;
      // x lerp products
      n0_4 <= n[0];
      n2_4 <= n[2];
      pt4 <= d_top * $signed({1'b0, u3});
      pb4 <= d_bot * $signed({1'b0, u3});
      v4w <= v3w;
      // x lerp results
      top5 <= $signed({1'b0, n0_4}) + 25'(pt4 >>> 16);
      bot5 <= $signed({1'b0, n2_4}) + 25'(pb4 >>> 16);
      v5w <= v4w;
      // z lerp
      dv6 <= vmix * $signed({1'b0, v5w});
      top6 <= top5;
      value <= 24'(top6 + 25'(dv6 >>> 16));
    end
  end

  assign out_valid = v[6];
  assign out_tag = tg[6];

endmodule

[src/thvn_back.sv]
// back end: octave sequencer, fractal accumulation and height shaping pipeline
module thvn_back (
  input  logic             clk,
  input  logic             rst,
  input  thvn_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  thvn_pkg::coord_t q_head,
  output logic             q_pop,
  thvn_hgt_if.source       terrain
);

  localparam int unsigned NC = 11;

  logic en;
  thvn_pkg::coord_t cur;
  logic cur_valid;
  logic [3:0] job;
  thvn_pkg::tag_t jt;
  logic signed [thvn_pkg::CW-1:0] sxs, szs;
  logic [thvn_pkg::NW-1:0] nx, nz;

  logic nz_valid;
  thvn_pkg::tag_t nz_tag;
  logic [23:0] nz_value;

  logic [29:0] acc, acc_next, s_cont, s_base;
  logic [NC-1:0] cv;

  logic [29:0] sc0, sb0, sr0, sc1, sb1, sr1;
  logic [26:0] qc1, qb1, qr1;
  logic [23:0] qc2, qb2, qr2;
  logic signed [25:0] cont3, base3, tdiff;
  logic [24:0] ridge3, t3, rn2, fold;
  logic signed [26:0] t2;
  logic [24:0] rr4, tt4, ridge4, t4;
  logic signed [51:0] pl4, ph4;
  logic [24:0] r35, mm5;
  logic [26:0] m3w;
  logic signed [26:0] lh5, lh6, lh7;
  logic [24:0] rm6;
  logic [26:0] rk7;
  logic signed [27:0] g8;
  logic signed [48:0] hp9;
  logic signed [24:0] hs;
  logic signed [41:0] hwp;
  logic signed [33:0] hw10;
  logic signed [34:0] hsum;
  logic out_v;
  logic signed [31:0] hgt;

  function automatic logic [26:0] recip_q(input logic [29:0] s, input logic [32:0] m);
    logic [62:0] p;
    p = 63'(s) * 63'(m);
    return 27'(p >> 36);
  endfunction

  function automatic logic [23:0] fix_q(input logic [29:0] s, input logic [26:0] q0,
                                        input logic [5:0] d);
    logic [31:0] r;
    r = 32'(s) - 32'(q0) * 32'(d);
    return (r >= 32'(d)) ? 24'(q0 + 27'd1) : 24'(q0);
  endfunction

  // the whole back end holds while a finished height waits at the output
  assign en = !(out_v && !terrain.ready);
  assign q_pop = en && q_valid && (!cur_valid || job == 4'(thvn_pkg::JOBS - 1));
  assign jt = thvn_pkg::job_decode(job);

  always_comb begin
    case (jt.frac)
      thvn_pkg::FRAC_CONT: begin
        sxs = cur.cx;
        szs = cur.cz;
      end
      thvn_pkg::FRAC_BASE: begin
        sxs = cur.fx;
        szs = cur.fz;
      end
      default: begin
        sxs = cur.rx;
        szs = cur.rz;
      end
    endcase
  end

  assign nx = {{(thvn_pkg::NW - thvn_pkg::CW){sxs[thvn_pkg::CW-1]}}, sxs} << jt.oct;
  assign nz = {{(thvn_pkg::NW - thvn_pkg::CW){szs[thvn_pkg::CW-1]}}, szs} << jt.oct;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      job <= '0;
    end else if (en) begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        job <= '0;
      end else if (cur_valid) begin
        if (job == 4'(thvn_pkg::JOBS - 1)) begin
          cur_valid <= 1'b0;
        end else begin
          job <= job + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  thvn_noise u_noise (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cur_valid),
    .in_tag    (jt),
    .x         (nx),
    .z         (nz),
    .seed      (cfg.seed),
    .out_valid (nz_valid),
    .out_tag   (nz_tag),
    .value     (nz_value)
  );

  assign acc_next = (nz_tag.first ? 30'd0 : acc) + (30'(nz_value) << nz_tag.shift);

  always_ff @(posedge clk) begin
    if (en && nz_valid) begin
      acc <= acc_next;
      if (nz_tag.last_frac && nz_tag.frac == thvn_pkg::FRAC_CONT) begin
        s_cont <= acc_next;
      end
      if (nz_tag.last_frac && nz_tag.frac == thvn_pkg::FRAC_BASE) begin
        s_base <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      cv <= {cv[NC-2:0], nz_valid && nz_tag.last_item};
      out_v <= cv[NC-1];
    end
  end

  // shaping arithmetic
  always_comb begin
    tdiff = cont3 - thvn_pkg::EDGE0;
    t2 = {tdiff[25], tdiff} <<< 1;
    rn2 = {qr2, 1'b0};
    fold = (rn2 >= 25'd16777216) ? rn2 - 25'd16777216 : 25'd16777216 - rn2;
    m3w = 27'd50331648 - 27'({t4, 1'b0});
    hs = 25'(hp9 >>> 24);
    hwp = hs * $signed({1'b0, cfg.water_depth});
    hsum = 35'(hw10) + 35'(cfg.shore_level);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc0 <= s_cont;
      sb0 <= s_base;
      sr0 <= acc_next;
      sc1 <= sc0;
      sb1 <= sb0;
      sr1 <= sr0;
      qc1 <= recip_q(sc0, thvn_pkg::RECIP_CONT);
      qb1 <= recip_q(sb0, thvn_pkg::RECIP_BASE);
      qr1 <= recip_q(sr0, thvn_pkg::RECIP_RIDGE);
      qc2 <= fix_q(sc1, qc1, thvn_pkg::DIV_CONT);
      qb2 <= fix_q(sb1, qb1, thvn_pkg::DIV_BASE);
      qr2 <= fix_q(sr1, qr1, thvn_pkg::DIV_RIDGE);
      cont3 <= $signed({1'b0, qc2, 1'b0}) - thvn_pkg::Q24_ONE_S;
      base3 <= $signed({1'b0, qb2, 1'b0}) - thvn_pkg::Q24_ONE_S;
      ridge3 <= 25'd16777216 - fold;
      t3 <= 25'd0;
      if (t2 > 27'sd16777216) begin
        t3 <= 25'd16777216;
      end else if (t2 >= 27'sd0) begin
        t3 <= 25'(t2);
      end
      rr4 <= 25'((50'(ridge3) * 50'(ridge3)) >> 24);
      tt4 <= 25'((50'(t3) * 50'(t3)) >> 24);
      pl4 <= cont3 * thvn_pkg::K_LAND;
      ph4 <= base3 * thvn_pkg::K_HILL;
      ridge4 <= ridge3;
      t4 <= t3;
      r35 <= 25'((50'(rr4) * 50'(ridge4)) >> 24);
      mm5 <= 25'((52'(tt4) * 52'(m3w)) >> 24);
      lh5 <= 27'((pl4 + ph4) >>> 24);
      rm6 <= 25'((50'(r35) * 50'(mm5)) >> 24);
      lh6 <= lh5;
      rk7 <= 27'((52'(rm6) * 52'(thvn_pkg::K_RIDGE)) >> 24);
      lh7 <= lh6;
      g8 <= lh7 + $signed({1'b0, rk7});
      hp9 <= g8 * $signed({1'b0, cfg.amplitude});
      // underwater heights scaled by water depth
      hw10 <= hs[24] ? 34'(hwp >>> 8) : {{9{hs[24]}}, hs};
      if (cv[NC-1]) begin
        if (hsum > 35'sd2147483647) begin
          hgt <= 32'sh7FFFFFFF;
        end else if (hsum < -35'sd2147483648) begin
          hgt <= 32'sh80000000;
        end else begin
          hgt <= 32'(hsum);
        end
      end
    end
  end

  assign terrain.valid = out_v;
  assign terrain.height = hgt;

  a_job_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> job < 4'(thvn_pkg::JOBS))
    else $error("octave job out of range");

  a_item_end: assert property (@(posedge clk) disable iff (rst)
    nz_valid && nz_tag.last_item |-> nz_tag.last_frac && nz_tag.frac == thvn_pkg::FRAC_RIDGE)
    else $error("item ends outside the ridge sum");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cv) && $stable(cur_valid))
    else $error("back end moved while stalled");

endmodule

[src/terrain_height_value_noise.sv]
// top level: config registers, front end, coordinate queue and back end
// the back end takes a new position word while the octaves of the previous one are still in the single shared noise
//   pipeline, which evaluates one lattice sample per cycle unless the back end stalls (4 + 6 + 5 octaves)
// the front end and its 4-entry queue accept words while the back end works
// reset (synchronous, active high) empties all pipelines and the queue and loads
//   register defaults; no clearing pass, words are taken right after reset
module terrain_height_value_noise (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [2:0]  write_index,
  input  logic [31:0] write_data,
  thvn_pos_if.sink    position,
  thvn_hgt_if.source  terrain
);

  thvn_pkg::cfg_t cfg;

  // front to queue
  logic             push_valid;
  thvn_pkg::coord_t push_word;
  logic             q_full;
  // queue to back
  logic             q_valid;
  thvn_pkg::coord_t q_head;
  logic             q_pop;

  // configuration registers, to be written by the user only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed <= 32'sd1337;
      cfg.amplitude <= 20'd15360;
      cfg.frequency <= 24'd41943;
      cfg.shore_level <= 24'sd0;
      cfg.water_depth <= 16'd256;
    end else if (write_en) begin
      case (write_index)
        thvn_pkg::REG_SEED:        cfg.seed <= write_data;
        thvn_pkg::REG_AMPLITUDE:   cfg.amplitude <= write_data[19:0];
        thvn_pkg::REG_FREQUENCY:   cfg.frequency <= write_data[23:0];
        thvn_pkg::REG_SHORE_LEVEL: cfg.shore_level <= write_data[23:0];
        thvn_pkg::REG_WATER_DEPTH: cfg.water_depth <= write_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // position scaling: three stages, stalls only when the queue is full
  thvn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frequency  (cfg.frequency),
    .position   (position),
    .full       (q_full),
    .push_valid (push_valid),
    .push_word  (push_word)
  );

  // decouples the front end from the octave-sequenced back end
  thvn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_word  (push_word),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  // octave sequencing, noise, fractal sums and height shaping
  thvn_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .terrain (terrain)
  );

endmodule
